// File: rtl/swvw_pkg.sv
// Shared types and constants for the spatial hash vertex weld block.
package swvw_pkg;

    // Hash multipliers, applied to the coordinates read as unsigned values
    localparam logic [31:0] HASH_PRIME_X = 32'd73856093;
    localparam logic [31:0] HASH_PRIME_Y = 32'd19349663;
    localparam logic [31:0] HASH_PRIME_Z = 32'd83492791;

    // Smallest table size in use, as log2
    localparam logic [4:0] MIN_LOG2 = 5'd6;
    localparam logic [3:0] SIZE_LOG2_RESET = 4'd12;

    localparam int COORD_W = 16;
    localparam int KEY_W   = 3 * COORD_W;
    localparam int ID_W    = 12;

    // Operation codes
    localparam logic OP_FIND  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef logic [KEY_W-1:0] key_t;

    // One input item
    typedef struct packed {
        logic                      op;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } vertex_t;

    // One result item
    typedef struct packed {
        logic [ID_W-1:0] position_id;
        logic            is_new;
        logic            table_full;
    } result_t;

endpackage

// File: rtl/spatial_hash_vertex_weld.sv
// Top level of the spatial hash vertex weld block: config register and part wiring.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  vertex   | push / full         | op, pos_x, pos_y, pos_z (vertex_t)
//  result   | pop / empty         | position_id, is_new, table_full (result_t)
//  config   | cfg_we              | cfg_data: table_size_log2
//
//  A find item is popped in S_IDLE, which reads its first slot, and is then probed in S_PROBE,
//  one slot memory read per cycle, until a hit, an empty slot or every slot in use is probed.
//  A clear item sweeps the slot memory one entry a cycle.
//  After reset the same sweep runs over the whole slot memory before any item is probed.
//  The front end registers the hash products and keeps up to five items buffered, so input
//  and result sides stall independently.
module spatial_hash_vertex_weld #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  swvw_pkg::vertex_t vertex,
    input  logic              pop,
    output logic              empty,
    output swvw_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [3:0]        cfg_data
);
    import swvw_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int QW = 1 + KEY_W + AW;

    logic [3:0]    size_log2_reg;
    logic [4:0]    lg_clamp;
    logic [4:0]    eff_log2;
    logic [AW:0]   size_one_hot;
    logic [AW-1:0] mask;
    logic          q_push, q_full, q_pop, q_empty;
    logic [QW-1:0] q_wdata, q_rdata;

    // Table size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= SIZE_LOG2_RESET;
        end
        else if (cfg_we)
        begin
            size_log2_reg <= cfg_data;
        end
    end

    // Slots in use: at least the minimum, at most the physical depth
    always_comb
    begin
        lg_clamp     = ({1'b0, size_log2_reg} < MIN_LOG2) ? MIN_LOG2 : {1'b0, size_log2_reg};
        eff_log2     = (lg_clamp > 5'(AW)) ? 5'(AW) : lg_clamp;
        size_one_hot = (AW+1)'(1) << eff_log2;
        mask         = AW'(size_one_hot - 1'b1);
    end

    swvw_front #(
        .AW (AW)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .vertex (vertex),
        .mask   (mask),
        .q_push (q_push),
        .q_full (q_full),
        .q_data (q_wdata)
    );

    swvw_queue #(
        .W (QW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .q_empty (q_empty)
    );

    swvw_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .mask    (mask),
        .q_data  (q_rdata),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// File: rtl/swvw_front.sv
// Front end: accepts items, hashes the position and hands them to the queue.
module swvw_front #(
    parameter int AW = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  swvw_pkg::vertex_t vertex,
    input  logic [AW-1:0]     mask,
    output logic              q_push,
    input  logic              q_full,
    output logic [AW+48:0]    q_data
);
    import swvw_pkg::*;

    logic          f_valid_reg, f_valid_next;
    logic          f_op_reg;
    key_t          f_key_reg;
    logic [31:0]   f_px_reg, f_py_reg, f_pz_reg;
    logic          accept;
    logic [31:0]   x_ext, y_ext, z_ext;
    logic [31:0]   hash;
    logic [AW-1:0] start_idx;

    // Holding stage: full while an item waits for a queue slot
    assign full   = f_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = f_valid_reg && !q_full;

    assign x_ext = 32'($unsigned(vertex.pos_x));
    assign y_ext = 32'($unsigned(vertex.pos_y));
    assign z_ext = 32'($unsigned(vertex.pos_z));

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    // Products registered, combined in the next cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_op_reg  <= vertex.op;
            f_key_reg <= {$unsigned(vertex.pos_z), $unsigned(vertex.pos_y),
                          $unsigned(vertex.pos_x)};
            f_px_reg  <= 32'(x_ext * HASH_PRIME_X);
            f_py_reg  <= 32'(y_ext * HASH_PRIME_Y);
            f_pz_reg  <= 32'(z_ext * HASH_PRIME_Z);
        end
    end

    assign hash      = f_px_reg ^ f_py_reg ^ f_pz_reg;
    assign start_idx = hash[AW-1:0] & mask;
    assign q_data    = {f_op_reg, f_key_reg, start_idx};

endmodule

// File: rtl/swvw_queue.sv
// Short FIFO between the hashing front end and the probe engine.
module swvw_queue #(
    parameter int W = 61
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         q_full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         q_empty
);
    localparam int QDEPTH = 4;
    localparam int PW     = $clog2(QDEPTH);
    localparam int CW     = $clog2(QDEPTH + 1);

    logic [W-1:0]  slots_reg [QDEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign q_full  = (count_reg == CW'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slots_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = do_wr ? PW'(wptr_reg + 1'b1) : wptr_reg;
        rptr_next  = do_rd ? PW'(rptr_reg + 1'b1) : rptr_reg;
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/swvw_back.sv
// Probe engine: slot memory, linear probing, clearing sweeps and result register.
module swvw_back #(
    parameter int TABLE_DEPTH = 4096,
    parameter int AW          = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [AW-1:0]     mask,
    input  logic [AW+48:0]    q_data,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output swvw_pkg::result_t result
);
    import swvw_pkg::*;

    localparam int MW = 1 + ID_W + KEY_W;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_PROBE,
        S_CLEAR
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   sweep_reg, sweep_next;
    key_t            key_reg, key_next;
    logic [ID_W:0]   next_id_reg, next_id_next;
    logic            out_valid_reg, out_valid_next;
    result_t         out_reg, out_next;

    logic [MW-1:0]   mem [TABLE_DEPTH];
    logic [MW-1:0]   rdata_reg;
    logic            mem_we;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [MW-1:0]   wr_data;

    logic            q_op;
    key_t            q_key;
    logic [AW-1:0]   q_idx;
    logic [AW-1:0]   step_idx;
    logic            r_valid;
    logic [ID_W-1:0] r_id;
    key_t            r_key;
    logic            out_free;

    assign q_op  = q_data[AW+KEY_W];
    assign q_key = q_data[AW+KEY_W-1:AW];
    assign q_idx = q_data[AW-1:0];

    assign r_valid = rdata_reg[MW-1];
    assign r_id    = rdata_reg[KEY_W+ID_W-1:KEY_W];
    assign r_key   = rdata_reg[KEY_W-1:0];

    assign step_idx = AW'(idx_reg + 1'b1) & mask;
    assign out_free = !out_valid_reg || pop;
    assign rd_addr  = (state_reg == S_IDLE) ? q_idx : step_idx;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        sweep_next     = sweep_reg;
        key_next       = key_reg;
        next_id_next   = next_id_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = '0;
        q_pop          = 1'b0;

        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                mem_we     = 1'b1;
                wr_addr    = sweep_reg;
                sweep_next = AW'(sweep_reg + 1'b1);
                if (sweep_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                    if (state_reg == S_CLEAR)
                    begin
                        next_id_next   = '0;
                        out_valid_next = 1'b1;
                        out_next       = '0;
                    end
                end
            end
            S_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_op == OP_CLEAR)
                    begin
                        sweep_next = '0;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        key_next   = q_key;
                        idx_next   = q_idx;
                        cnt_next   = '0;
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (!r_valid)
                begin
                    // Empty slot: insert with the next dense id
                    mem_we                = 1'b1;
                    wr_data               = {1'b1, next_id_reg[ID_W-1:0], key_reg};
                    next_id_next          = (ID_W+1)'(next_id_reg + 1'b1);
                    out_next.position_id  = next_id_reg[ID_W-1:0];
                    out_next.is_new       = 1'b1;
                    out_next.table_full   = 1'b0;
                    out_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
                else if (r_key == key_reg)
                begin
                    out_next.position_id = r_id;
                    out_next.is_new      = 1'b0;
                    out_next.table_full  = 1'b0;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
                else if (cnt_reg == mask)
                begin
                    // Every slot in use probed without a hit
                    out_next.position_id = '0;
                    out_next.is_new      = 1'b0;
                    out_next.table_full  = 1'b1;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
                else
                begin
                    idx_next = step_idx;
                    cnt_next = AW'(cnt_reg + 1'b1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        out_reg <= out_next;
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Result register is always free while probing
    a_probe_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROBE |-> !out_valid_reg)
        else $error("result register busy during probe");

    // Probe count never runs past the slots in use
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROBE |-> cnt_reg <= mask)
        else $error("probe count past table size");

    // A result appears only at the end of a probe or a clear sweep
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_PROBE ||
                                  $past(state_reg) == S_CLEAR))
        else $error("result from unexpected state");

    // Ids restart after a clear sweep
    a_clear_ids: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && state_next == S_IDLE) |=> next_id_reg == '0)
        else $error("id counter not restarted by clear");

endmodule

// File: verif/tb_spatial_hash_vertex_weld.sv
// Testbench for spatial_hash_vertex_weld: directed and random vertex traffic against a predictor.
module tb_spatial_hash_vertex_weld;
    timeunit 1ns;
    timeprecision 1ps;

    import swvw_pkg::*;

    localparam int          SLOT_COUNT  = 4096;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          POOL_DEPTH  = 48;

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      push     = 1'b0;
    logic      full;
    vertex_t   vertex   = '0;
    logic      pop      = 1'b0;
    logic      empty;
    result_t   result;
    logic      cfg_we   = 1'b0;
    logic [3:0] cfg_data = 4'd0;

    // Idle percentages for the two sides
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;

    // Predicted results, oldest first
    result_t awaited_results[$];

    // Recent find positions, reused to hit stored entries
    vertex_t recent_positions[$];

    // Predictor state: hash slots, id counter, table size register
    bit          slot_used [SLOT_COUNT];
    key_t        slot_key  [SLOT_COUNT];
    logic [11:0] slot_tag  [SLOT_COUNT];
    logic [12:0] next_id    = '0;
    logic [3:0]  table_log2 = SIZE_LOG2_RESET;

    spatial_hash_vertex_weld #(
        .TABLE_DEPTH(SLOT_COUNT)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .vertex  (vertex),
        .pop     (pop),
        .empty   (empty),
        .result  (result),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Find-or-insert on the predicted table; updates state like the block does
    function automatic result_t weld_predict(vertex_t v);
        result_t     r;
        logic [15:0] ux;
        logic [15:0] uy;
        logic [15:0] uz;
        key_t        key;
        logic [31:0] h;
        int unsigned lg;
        int unsigned n_slots;
        int unsigned slot;
        int unsigned k;
        r = '0;
        if (v.op == OP_CLEAR)
        begin
            foreach (slot_used[j])
                slot_used[j] = 1'b0;
            next_id = '0;
            return r;
        end
        ux  = v.pos_x;
        uy  = v.pos_y;
        uz  = v.pos_z;
        key = {uz, uy, ux};
        // size clamp: at least MIN_LOG2, at most the physical depth
        lg = table_log2;
        if (lg < MIN_LOG2)
            lg = MIN_LOG2;
        n_slots = 1 << lg;
        while (n_slots > SLOT_COUNT)
            n_slots = n_slots >> 1;
        h = ({16'd0, ux} * HASH_PRIME_X) ^ ({16'd0, uy} * HASH_PRIME_Y)
            ^ ({16'd0, uz} * HASH_PRIME_Z);
        slot = h & (n_slots - 1);
        // linear probe, wrapping inside the slots in use
        for (k = 0; k < n_slots; k++)
        begin
            if (!slot_used[slot])
            begin
                slot_used[slot] = 1'b1;
                slot_key[slot]  = key;
                slot_tag[slot]  = next_id[11:0];
                r.position_id   = next_id[11:0];
                r.is_new        = 1'b1;
                next_id         = next_id + 13'd1;
                return r;
            end
            if (slot_key[slot] == key)
            begin
                r.position_id = slot_tag[slot];
                return r;
            end
            slot = (slot + 1) & (n_slots - 1);
        end
        r.table_full = 1'b1;
        return r;
    endfunction

    // Send one item; push stays high so back-to-back items need no extra toggle
    task automatic send_vertex(vertex_t v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push   <= 1'b1;
        vertex <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        awaited_results.push_back(weld_predict(v));
    endtask

    // Stop sending and wait for every predicted result to come back
    task automatic drain_results();
        push <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Table size register write, only while the block is idle
    task automatic set_table_size(logic [3:0] lg);
        cfg_we   <= 1'b1;
        cfg_data <= lg;
        @(posedge clk);
        cfg_we     <= 1'b0;
        table_log2 = lg;
    endtask

    function automatic vertex_t make_vertex(logic op, logic [15:0] x, logic [15:0] y,
                                            logic [15:0] z);
        vertex_t v;
        v.op    = op;
        v.pos_x = x;
        v.pos_y = y;
        v.pos_z = z;
        return v;
    endfunction

    // Distinct position per index, for table fills
    function automatic vertex_t grid_vertex(int k);
        return make_vertex(OP_FIND, 16'(k), 16'(3 * k + 1), 16'(-k - 7));
    endfunction

    function automatic logic [15:0] random_coord();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return $urandom_range(1) ? 16'h0000 : 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly finds, about half of them repeats or near repeats; rare clears
    function automatic vertex_t random_vertex();
        vertex_t v;
        if ($urandom_range(119) == 0)
            return make_vertex(OP_CLEAR, random_coord(), random_coord(), random_coord());
        if (recent_positions.size() != 0 && $urandom_range(99) < 55)
        begin
            v = recent_positions[$urandom_range(recent_positions.size() - 1)];
            // near miss: one coordinate off by its low bit
            if ($urandom_range(3) == 0)
                v.pos_y = v.pos_y ^ 16'sd1;
            return v;
        end
        v = make_vertex(OP_FIND, random_coord(), random_coord(), random_coord());
        recent_positions.push_back(v);
        if (recent_positions.size() > POOL_DEPTH)
            void'(recent_positions.pop_front());
        return v;
    endfunction

    task automatic flag_result_error(string what, result_t want, result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("result error (%s): expected id %0d new %0d full %0d, got id %0d new %0d full %0d",
                     what, want.position_id, want.is_new, want.table_full,
                     got.position_id, got.is_new, got.table_full);
    endtask

    // Coordinate extremes, repeats, single-coordinate differences, clears
    task automatic test_directed_extremes();
        send_vertex(make_vertex(OP_FIND, 16'h8000, 16'h8000, 16'h8000));
        send_vertex(make_vertex(OP_FIND, 16'h7fff, 16'h7fff, 16'h7fff));
        send_vertex(make_vertex(OP_FIND, 16'h0000, 16'h0000, 16'h0000));
        send_vertex(make_vertex(OP_FIND, 16'hffff, 16'hffff, 16'hffff));
        send_vertex(make_vertex(OP_FIND, 16'h8000, 16'h7fff, 16'h0000));
        send_vertex(make_vertex(OP_FIND, 16'h7fff, 16'h8000, 16'hffff));
        send_vertex(make_vertex(OP_FIND, 16'h0000, 16'h0000, 16'h0001));
        send_vertex(make_vertex(OP_FIND, 16'h0000, 16'h0001, 16'h0000));
        send_vertex(make_vertex(OP_FIND, 16'h0001, 16'h0000, 16'h0000));
        send_vertex(make_vertex(OP_FIND, 16'h8000, 16'h8000, 16'h8000));
        send_vertex(make_vertex(OP_FIND, 16'h0000, 16'h0000, 16'h0000));
        // clear ignores its position fields
        send_vertex(make_vertex(OP_CLEAR, 16'hffff, 16'hffff, 16'hffff));
        send_vertex(make_vertex(OP_FIND, 16'h7fff, 16'h7fff, 16'h7fff));
        send_vertex(make_vertex(OP_FIND, 16'h8000, 16'h8000, 16'h8000));
        send_vertex(make_vertex(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000));
        send_vertex(make_vertex(OP_FIND, 16'h0001, 16'h0002, 16'h0003));
    endtask

    // Register values below and above the legal range get clamped
    task automatic test_size_clamping();
        drain_results();
        set_table_size(4'd0);
        send_vertex(make_vertex(OP_FIND, 16'h1234, 16'h5678, 16'h9abc));
        send_vertex(make_vertex(OP_FIND, 16'h0040, 16'h0000, 16'h0000));
        send_vertex(make_vertex(OP_FIND, 16'h1234, 16'h5678, 16'h9abc));
        drain_results();
        set_table_size(4'd15);
        send_vertex(make_vertex(OP_FIND, 16'h0001, 16'h0002, 16'h0003));
        send_vertex(make_vertex(OP_FIND, 16'hfedc, 16'hba98, 16'h7654));
        send_vertex(make_vertex(OP_FIND, 16'h1234, 16'h5678, 16'h9abc));
        drain_results();
        set_table_size(4'd5);
        send_vertex(make_vertex(OP_FIND, 16'hfedc, 16'hba98, 16'h7654));
        send_vertex(make_vertex(OP_FIND, 16'h0002, 16'h0004, 16'h0006));
    endtask

    // Fill the smallest table, then probe it full
    task automatic test_table_full();
        drain_results();
        set_table_size(4'd6);
        send_vertex(make_vertex(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000));
        for (int k = 0; k < 64; k++)
            send_vertex(grid_vertex(k));
        send_vertex(grid_vertex(64));
        send_vertex(grid_vertex(65));
        // stored entries are still found in a full table
        send_vertex(grid_vertex(17));
        send_vertex(grid_vertex(63));
        send_vertex(grid_vertex(64));
    endtask

    // Grow and shrink the table without clearing it
    task automatic test_resize_without_clear();
        drain_results();
        set_table_size(4'd7);
        for (int k = 64; k < 96; k++)
            send_vertex(grid_vertex(k));
        for (int k = 0; k < 8; k++)
            send_vertex(grid_vertex(k));
        drain_results();
        // entries placed in the upper half are no longer seen
        set_table_size(4'd6);
        for (int k = 64; k < 72; k++)
            send_vertex(grid_vertex(k));
        for (int k = 0; k < 4; k++)
            send_vertex(grid_vertex(k));
        send_vertex(make_vertex(OP_CLEAR, 16'h5a5a, 16'ha5a5, 16'h0f0f));
        send_vertex(grid_vertex(70));
    endtask

    task automatic test_random_traffic(int count, logic [3:0] lg, int unsigned send_pct,
                                       int unsigned recv_pct);
        drain_results();
        set_table_size(lg);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++)
            send_vertex(random_vertex());
    endtask

    // Result side: random pop, compare each accepted item with the oldest prediction
    initial
    begin : result_checker
        result_t got;
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                got = result;
                if (awaited_results.size() == 0)
                begin
                    flag_result_error("unexpected", '0, got);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.position_id !== want.position_id || got.is_new !== want.is_new
                        || got.table_full !== want.table_full)
                        flag_result_error("field", want, got);
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("spatial_hash_vertex_weld: mismatch");
        $finish;
    end

    initial
    begin : test_sequence
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 31;
        recv_idle_pct = 65;
        test_directed_extremes();
        test_size_clamping();
        test_table_full();
        test_resize_without_clear();
        test_random_traffic(380, 4'd0, 31, 65);
        test_random_traffic(380, 4'd9, 65, 31);
        test_random_traffic(390, 4'd15, 0, 0);
        drain_results();
        // a clear can still be sweeping; leave room for stray results
        repeat (SLOT_COUNT + 16) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("spatial_hash_vertex_weld: match");
        else
            $display("spatial_hash_vertex_weld: mismatch");
        $finish;
    end

endmodule
